// ===== rtl/core/directional_span_binary_search_assert.svh =====
// assertion macros for the span search block
`ifndef DIRECTIONAL_SPAN_BINARY_SEARCH_ASSERT_SVH
`define DIRECTIONAL_SPAN_BINARY_SEARCH_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DSBS_ASSERT_SAME(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("span search assertion failed");
`define DSBS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("span search assertion failed");
`else
`define DSBS_ASSERT_SAME(label, clk, rst_n, pre, post)
`define DSBS_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/core/dsbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dsbs_pkg;
	localparam int FRAMES = 6;
	localparam int INDEX_SLOTS = 4096;
	localparam int SPANS_PER_FRAME_DEF = 4096;

	localparam int OP_W = 1;
	localparam int FRAME_W = 3;
	localparam int IDX_W = 12;
	localparam int START_W = 32;
	localparam int LEN_W = 16;
	localparam int POS_W = 32;
	localparam int ENTRY_W = START_W + LEN_W;

	localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
	localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

	localparam logic [FRAME_W-1:0] FRAME_LIMIT = 3'd6;
	localparam logic [FRAME_W-1:0] FWD_LIMIT = 3'd3;

	typedef struct packed {
		logic load;
		logic start;
		logic probe_rd;
		logic probe_upd;
		logic final_rd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic more;
		logic more_nxt;
		logic out_busy;
	} sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/dsbs_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface dsbs_req_if;
	logic valid;
	logic ready;
	logic [dsbs_pkg::OP_W-1:0] op;
	logic [dsbs_pkg::FRAME_W-1:0] frame;
	logic [dsbs_pkg::IDX_W-1:0] entry_index;
	logic [dsbs_pkg::START_W-1:0] entry_start;
	logic [dsbs_pkg::LEN_W-1:0] entry_length;
	logic [dsbs_pkg::POS_W-1:0] query_position;

	modport source (
		output valid, op, frame, entry_index, entry_start, entry_length, query_position,
		input ready
	);
	modport sink (
		input valid, op, frame, entry_index, entry_start, entry_length, query_position,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/core/dsbs_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface dsbs_rsp_if;
	logic valid;
	logic ready;
	logic [dsbs_pkg::START_W-1:0] span_start;
	logic [dsbs_pkg::LEN_W-1:0] span_length;
	logic table_empty;

	modport source (
		output valid, span_start, span_length, table_empty,
		input ready
	);
	modport sink (
		input valid, span_start, span_length, table_empty,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/core/dsbs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dsbs_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic [dsbs_pkg::OP_W-1:0] in_op,
	output logic in_ready,
	input  dsbs_pkg::sts_t sts,
	output dsbs_pkg::cmd_t cmd
);
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_PROBE_RD,
		ST_PROBE_CMP,
		ST_FINAL_RD,
		ST_FINAL_OUT
	} state_t;

	state_t state_q;
	logic fire;

	assign in_ready = (state_q == ST_IDLE);
	assign fire = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.load = fire && (in_op == dsbs_pkg::OP_LOAD);
		cmd.start = fire && (in_op == dsbs_pkg::OP_QUERY);
		cmd.probe_rd = (state_q == ST_PROBE_RD);
		cmd.probe_upd = (state_q == ST_PROBE_CMP);
		cmd.final_rd = (state_q == ST_FINAL_RD);
		cmd.out_load = (state_q == ST_FINAL_OUT) && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (fire && (in_op == dsbs_pkg::OP_QUERY)) state_q <= ST_START;
				end
				ST_START: begin
					if (sts.empty) state_q <= ST_FINAL_OUT;
					else if (sts.more) state_q <= ST_PROBE_RD;
					else state_q <= ST_FINAL_RD;
				end
				ST_PROBE_RD: begin
					state_q <= ST_PROBE_CMP;
				end
				ST_PROBE_CMP: begin
					if (sts.more_nxt) state_q <= ST_PROBE_RD;
					else state_q <= ST_FINAL_RD;
				end
				ST_FINAL_RD: begin
					state_q <= ST_FINAL_OUT;
				end
				ST_FINAL_OUT: begin
					if (!sts.out_busy) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/dsbs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dsbs_datapath #(
	parameter int SPANS_PER_FRAME = dsbs_pkg::SPANS_PER_FRAME_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [dsbs_pkg::FRAME_W-1:0] in_frame,
	input  wire logic [dsbs_pkg::IDX_W-1:0] in_index,
	input  wire logic [dsbs_pkg::START_W-1:0] in_start,
	input  wire logic [dsbs_pkg::LEN_W-1:0] in_length,
	input  wire logic [dsbs_pkg::POS_W-1:0] in_position,
	input  dsbs_pkg::cmd_t cmd,
	output dsbs_pkg::sts_t sts,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [dsbs_pkg::START_W-1:0] out_start,
	output logic [dsbs_pkg::LEN_W-1:0] out_length,
	output logic out_empty
);
	localparam int SLOTS = (SPANS_PER_FRAME < dsbs_pkg::INDEX_SLOTS) ?
		SPANS_PER_FRAME : dsbs_pkg::INDEX_SLOTS;
	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int DEPTH = dsbs_pkg::FRAMES * SLOTS;
	localparam int AW = $clog2(DEPTH);
	localparam int SW = dsbs_pkg::START_W;
	localparam int LW = dsbs_pkg::LEN_W;
	localparam int WW = LW + 2;
	localparam logic [dsbs_pkg::IDX_W:0] SLOTS_LIM = (dsbs_pkg::IDX_W + 1)'(SLOTS);
	localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	logic [dsbs_pkg::ENTRY_W-1:0] mem [DEPTH];
	logic [dsbs_pkg::ENTRY_W-1:0] rd_q;
	logic [CW-1:0] cnt_q [dsbs_pkg::FRAMES];

	logic [dsbs_pkg::POS_W-1:0] pos_q;
	logic fwd_q;
	logic empty_q;
	logic [AW-1:0] base_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi1_q;

	logic frame_ok;
	logic wr_ok;
	logic [AW-1:0] in_base;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] cnt_sel;
	logic [CW-1:0] diff;
	logic [CW-1:0] mid;
	logic [IW-1:0] fin_idx;
	logic [IW-1:0] rd_idx;

	logic [SW-1:0] s;
	logic [LW-1:0] len;
	logic [WW-1:0] w;
	logic [SW+1:0] end_fwd;
	logic [SW+1:0] pos_w;
	logic lt_s;
	logic lt_e;
	logic gt_s;
	logic gt_e;
	logic brk;
	logic [CW-1:0] lo_nxt;
	logic [CW-1:0] hi1_nxt;

	assign frame_ok = (in_frame < dsbs_pkg::FRAME_LIMIT);
	assign wr_ok = frame_ok && ({1'b0, in_index} < SLOTS_LIM);
	assign in_base = AW'(in_frame) * AW'(SLOTS);
	assign wr_addr = in_base + AW'(in_index[IW-1:0]);
	assign cnt_sel = frame_ok ? cnt_q[in_frame] : '0;

	// midpoint of the live range, hi1 is one past the upper bound
	assign diff = hi1_q - lo_q - CW'(1);
	assign mid = lo_q + (diff >> 1);
	assign fin_idx = (lo_q == SLOTS_C) ? LAST_IDX : lo_q[IW-1:0];
	assign rd_idx = cmd.final_rd ? fin_idx : mid[IW-1:0];
	assign rd_addr = base_q + AW'(rd_idx);

	always_ff @(posedge clk) begin
		if (cmd.load && wr_ok) mem[wr_addr] <= {in_start, in_length};
		if (cmd.probe_rd || cmd.final_rd) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int f = 0; f < dsbs_pkg::FRAMES; f++) cnt_q[f] <= '0;
		end else if (cmd.load && wr_ok) begin
			cnt_q[in_frame] <= CW'({1'b0, in_index} + (dsbs_pkg::IDX_W + 1)'(1));
		end
	end

	// span compare, backward end test written as pos + 3*len > start
	assign s = rd_q[dsbs_pkg::ENTRY_W-1:LW];
	assign len = rd_q[LW-1:0];
	assign w = {2'b00, len} + {1'b0, len, 1'b0};
	assign end_fwd = {2'b00, s} + (SW + 2)'(w);
	assign pos_w = {2'b00, pos_q} + (SW + 2)'(w);
	assign lt_s = pos_q < s;
	assign lt_e = {2'b00, pos_q} < end_fwd;
	assign gt_s = pos_q > s;
	assign gt_e = pos_w > {2'b00, s};

	always_comb begin
		lo_nxt = lo_q;
		hi1_nxt = hi1_q;
		brk = 1'b0;
		if (fwd_q) begin
			if (lt_s) begin
				hi1_nxt = mid;
			end else if (lt_e) begin
				lo_nxt = mid;
				brk = 1'b1;
			end else begin
				lo_nxt = mid + CW'(1);
			end
		end else begin
			if (gt_s) begin
				lo_nxt = mid + CW'(1);
			end else if (gt_e) begin
				lo_nxt = mid;
				brk = 1'b1;
			end else begin
				hi1_nxt = mid;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= 1'b0;
		end else if (cmd.start) begin
			empty_q <= !frame_ok || (cnt_sel == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pos_q <= in_position;
			fwd_q <= (in_frame < dsbs_pkg::FWD_LIMIT);
			base_q <= in_base;
			lo_q <= '0;
			hi1_q <= cnt_sel;
		end else if (cmd.probe_upd) begin
			lo_q <= lo_nxt;
			hi1_q <= hi1_nxt;
		end
	end

	assign sts.empty = empty_q;
	assign sts.more = {1'b0, hi1_q} > ({1'b0, lo_q} + (CW + 1)'(1));
	assign sts.more_nxt = !brk && ({1'b0, hi1_nxt} > ({1'b0, lo_nxt} + (CW + 1)'(1)));
	assign sts.out_busy = out_valid && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_start <= empty_q ? '0 : s;
			out_length <= empty_q ? '0 : len;
			out_empty <= empty_q;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/directional_span_binary_search.sv =====
// Span lookup over six sorted span tables, one per reading frame.
// req channel: op selects a load (write entry_start/entry_length at
// entry_index of the frame's table, count becomes entry_index + 1) or a
// query (binary search for query_position in the frame's table).
// rsp channel: one word per query with span_start, span_length and
// table_empty; loads give no word.
// A load leaves the controller idle. A query holds req.ready low while it
// runs: a setup step, then per probe a memory read and then a compare on
// the single read port of the span memory, then a final read and the
// output step; an empty table or an unused frame skips the probes and the
// final read.
// The result sits in an output register; the next word is accepted while
// it waits. A finished query that finds the register still full waits for
// rsp.ready before releasing req.ready.
// Reset clears the frame counts, so every table reads as empty; span
// memory contents stay as they were and need no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "directional_span_binary_search_assert.svh"
module directional_span_binary_search #(
	parameter int SPANS_PER_FRAME = dsbs_pkg::SPANS_PER_FRAME_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	dsbs_req_if.sink req,
	dsbs_rsp_if.source rsp
);
	dsbs_pkg::cmd_t cmd;
	dsbs_pkg::sts_t sts;

	dsbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_op    (req.op),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dsbs_datapath #(
		.SPANS_PER_FRAME(SPANS_PER_FRAME)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_frame    (req.frame),
		.in_index    (req.entry_index),
		.in_start    (req.entry_start),
		.in_length   (req.entry_length),
		.in_position (req.query_position),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_start   (rsp.span_start),
		.out_length  (rsp.span_length),
		.out_empty   (rsp.table_empty)
	);

	`DSBS_ASSERT_SAME(a_out_load_free, clk, arst_n, cmd.out_load, !sts.out_busy)
	`DSBS_ASSERT_NEXT(a_start_busy, clk, arst_n, cmd.start, !req.ready)
	`DSBS_ASSERT_NEXT(a_rd_then_cmp, clk, arst_n, cmd.probe_rd, cmd.probe_upd)
	`DSBS_ASSERT_NEXT(a_out_after_load, clk, arst_n, cmd.out_load, rsp.valid)
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import dsbs_pkg::*;

	localparam int CODON_NT = 3;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 60;
	localparam longint TIMEOUT_NS = 20_000_000;
	localparam longint POS_MAX = 64'hFFFF_FFFF;

	typedef struct {
		logic [START_W-1:0] start;
		logic [LEN_W-1:0] length;
		logic empty;
	} span_word_t;

	class span_tracker;
		logic [START_W-1:0] starts [FRAMES][INDEX_SLOTS];
		logic [LEN_W-1:0] lens [FRAMES][INDEX_SLOTS];
		int unsigned counts [FRAMES];
		span_word_t expected_spans [$];
		int errors;

		function new();
			foreach (counts[f])
				counts[f] = 0;
			errors = 0;
		endfunction

		function int find_slot(int f, logic [POS_W-1:0] pos);
			longint lo, hi, mid, s, w, p;
			bit fwd;
			lo = 0;
			hi = longint'(counts[f]) - 1;
			p = longint'(pos);
			fwd = (f < int'(FWD_LIMIT));
			while (hi > lo) begin
				mid = lo + (hi - lo) / 2;
				s = longint'(starts[f][mid]);
				w = longint'(lens[f][mid]) * CODON_NT;
				if (fwd) begin
					if (p < s)
						hi = mid - 1;
					else if (p < s + w) begin
						lo = mid;
						break;
					end else
						lo = mid + 1;
				end else begin
					if (p > s)
						lo = mid + 1;
					else if (p > s - w) begin
						lo = mid;
						break;
					end else
						hi = mid - 1;
				end
			end
			if (lo < 0)
				lo = 0;
			if (lo >= INDEX_SLOTS)
				lo = INDEX_SLOTS - 1;
			return int'(lo);
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic [FRAME_W-1:0] frame,
				logic [IDX_W-1:0] idx, logic [START_W-1:0] st, logic [LEN_W-1:0] ln,
				logic [POS_W-1:0] pos);
			span_word_t w;
			int f, k;
			f = int'(frame);
			if (op == OP_LOAD) begin
				if (frame < FRAME_LIMIT && int'(idx) < SPANS_PER_FRAME_DEF) begin
					starts[f][idx] = st;
					lens[f][idx] = ln;
					counts[f] = int'(idx) + 1;
				end
			end else begin
				if (frame >= FRAME_LIMIT || counts[f] == 0) begin
					w.start = '0;
					w.length = '0;
					w.empty = 1'b1;
				end else begin
					k = find_slot(f, pos);
					w.start = starts[f][k];
					w.length = lens[f][k];
					w.empty = 1'b0;
				end
				expected_spans.push_back(w);
			end
		endfunction

		function void check_response(logic [START_W-1:0] st, logic [LEN_W-1:0] ln,
				logic empty);
			span_word_t w;
			if (expected_spans.size() == 0) begin
				$error("unexpected result word: span_start %h span_length %h table_empty %b",
					st, ln, empty);
				errors++;
				return;
			end
			w = expected_spans.pop_front();
			if (st !== w.start) begin
				$error("span_start mismatch: expected %h, got %h", w.start, st);
				errors++;
			end
			if (ln !== w.length) begin
				$error("span_length mismatch: expected %h, got %h", w.length, ln);
				errors++;
			end
			if (empty !== w.empty) begin
				$error("table_empty mismatch: expected %b, got %b", w.empty, empty);
				errors++;
			end
		endfunction

		function int outstanding();
			return expected_spans.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	dsbs_req_if req_bus ();
	dsbs_rsp_if rsp_bus ();

	directional_span_binary_search dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	span_tracker tracker = new();

	int tx_idle_pct = 35;
	int rx_idle_pct = 62;
	int stall_requests = 0;
	int words_sent = 0;
	int loaded_count [FRAMES];
	int prefix_len [FRAMES];
	logic [START_W-1:0] sent_start [FRAMES][INDEX_SLOTS];
	logic [LEN_W-1:0] sent_len [FRAMES][INDEX_SLOTS];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (req_bus.valid && req_bus.ready)
			tracker.note_request(req_bus.op, req_bus.frame, req_bus.entry_index,
				req_bus.entry_start, req_bus.entry_length, req_bus.query_position);
		if (rsp_bus.valid && rsp_bus.ready)
			tracker.check_response(rsp_bus.span_start, rsp_bus.span_length,
				rsp_bus.table_empty);
	end

	// receiver: random idling plus a long hold-off on request
	initial begin
		int hold_left;
		int stall_seen;
		hold_left = 0;
		stall_seen = 0;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_seen != stall_requests) begin
				stall_seen = stall_requests;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else
				rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb_top NOT OK");
		$finish;
	end

	task automatic send_word(logic [OP_W-1:0] op, int fr, logic [IDX_W-1:0] idx,
			logic [START_W-1:0] st, logic [LEN_W-1:0] ln, logic [POS_W-1:0] pos);
		bit idle;
		idle = 1'b0;
		while ($urandom_range(99) < tx_idle_pct) begin
			if (!idle) begin
				req_bus.valid <= 1'b0;
				idle = 1'b1;
			end
			@(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.op <= op;
		req_bus.frame <= FRAME_W'(fr);
		req_bus.entry_index <= idx;
		req_bus.entry_start <= st;
		req_bus.entry_length <= ln;
		req_bus.query_position <= pos;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
	endtask

	task automatic load_entry(int fr, int idx, logic [START_W-1:0] st,
			logic [LEN_W-1:0] ln);
		send_word(OP_LOAD, fr, IDX_W'(idx), st, ln, $urandom);
		if (fr < FRAMES) begin
			sent_start[fr][idx] = st;
			sent_len[fr][idx] = ln;
			loaded_count[fr] = idx + 1;
			if (idx == prefix_len[fr])
				prefix_len[fr]++;
			words_sent++;
		end
	endtask

	task automatic ask_span(int fr, longint pos);
		if (pos < 0)
			pos = 0;
		if (pos > POS_MAX)
			pos = POS_MAX;
		send_word(OP_QUERY, fr, IDX_W'($urandom), $urandom, LEN_W'($urandom),
			POS_W'(pos));
		words_sent++;
	endtask

	// sender pause until every result is back
	task automatic drain();
		req_bus.valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.outstanding() != 0);
	endtask

	function automatic logic [LEN_W-1:0] pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		else if (r < 80)
			return LEN_W'($urandom_range(1, 50));
		else if (r < 95)
			return LEN_W'($urandom_range(51, 2000));
		else if (r < 98)
			return LEN_W'($urandom_range(2001, 65535));
		return '1;
	endfunction

	function automatic int pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return $urandom_range(1, 8);
		else if (r < 85)
			return $urandom_range(9, 64);
		else if (r < 97)
			return $urandom_range(65, 300);
		return $urandom_range(301, 1200);
	endfunction

	task automatic build_table(int fr, int n, bit sorted);
		longint s, w;
		logic [LEN_W-1:0] ln;
		int r;
		r = $urandom_range(99);
		if (r < 40)
			s = $urandom_range(0, 2000);
		else if (r < 80)
			s = longint'($urandom);
		else
			s = POS_MAX - $urandom_range(0, 100000);
		for (int i = 0; i < n; i++) begin
			ln = pick_len();
			w = longint'(ln) * CODON_NT;
			if (fr >= int'(FWD_LIMIT) && i == 0)
				s = s + w;
			if (s > POS_MAX)
				s = POS_MAX;
			if (sorted)
				load_entry(fr, i, START_W'(s), ln);
			else
				load_entry(fr, i, $urandom, ln);
			if (fr < int'(FWD_LIMIT))
				s = s + w + $urandom_range(0, 40);
			else if (i + 1 < n)
				s = s + $urandom_range(0, 40);
			if (fr >= int'(FWD_LIMIT) && i + 1 < n) begin
				// next backward span ends at its own start
				s = s + 0;
			end
		end
	endtask

	task automatic probe_table(int fr);
		int n, i;
		longint s, w;
		bit fwd;
		n = loaded_count[fr];
		if (n == 0) begin
			ask_span(fr, longint'($urandom));
			return;
		end
		i = $urandom_range(n - 1);
		s = longint'(sent_start[fr][i]);
		w = longint'(sent_len[fr][i]) * CODON_NT;
		fwd = (fr < int'(FWD_LIMIT));
		case ($urandom_range(7))
			0: ask_span(fr, s);
			1: ask_span(fr, fwd ? s + w - 1 : s - w + 1);
			2: ask_span(fr, fwd ? s + w : s - w);
			3: begin
				if (w > 0)
					ask_span(fr, fwd ? s + $urandom_range(0, int'(w - 1))
						: s - $urandom_range(0, int'(w - 1)));
				else
					ask_span(fr, s);
			end
			4: ask_span(fr, s - 1);
			5: ask_span(fr, s + 1);
			6: ask_span(fr, longint'($urandom));
			default: ask_span(fr, $urandom_range(1) ? POS_MAX : 0);
		endcase
	endtask

	task automatic run_phase(int tx, int rx, int goal);
		int first, r, fr, n, nq, left;
		tx_idle_pct = tx;
		rx_idle_pct = rx;
		first = words_sent;
		while (words_sent - first < goal) begin
			r = $urandom_range(99);
			fr = $urandom_range(FRAMES - 1);
			if (r < 80) begin
				left = goal - (words_sent - first);
				n = pick_size();
				if (n > left)
					n = left;
				build_table(fr, n, r < 70);
				nq = $urandom_range(3, 8 + n / 3);
				if (nq > 60)
					nq = 60;
				left = goal - (words_sent - first);
				if (nq > left)
					nq = left;
				if (nq < 1)
					nq = 1;
				repeat (nq)
					probe_table(fr);
			end else if (r < 88) begin
				// shrink the table by rewriting a slot inside it
				if (loaded_count[fr] > 0)
					load_entry(fr, $urandom_range(loaded_count[fr] - 1), $urandom,
						pick_len());
				repeat ($urandom_range(1, 4))
					probe_table(fr);
			end else if (r < 94) begin
				repeat ($urandom_range(1, 6))
					probe_table($urandom_range(FRAMES - 1));
			end else begin
				fr = $urandom_range(FRAMES, 7);
				if ($urandom_range(1))
					load_entry(fr, $urandom_range(INDEX_SLOTS - 1), $urandom,
						LEN_W'($urandom));
				ask_span($urandom_range(7), longint'($urandom));
			end
		end
	endtask

	initial begin
		foreach (loaded_count[f]) begin
			loaded_count[f] = 0;
			prefix_len[f] = 0;
		end
		arst_n <= 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.op <= OP_LOAD;
		req_bus.frame <= '0;
		req_bus.entry_index <= '0;
		req_bus.entry_start <= '0;
		req_bus.entry_length <= '0;
		req_bus.query_position <= '0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty tables and unused frames
		ask_span(0, 0);
		ask_span(5, POS_MAX);
		ask_span(6, 12345);
		ask_span(7, 0);
		load_entry(7, INDEX_SLOTS - 1, '1, '1);
		load_entry(6, 1234, 32'h5555_5555, 16'hAAAA);
		ask_span(6, 0);

		// top slot, then shrink the count back to one
		load_entry(0, INDEX_SLOTS - 1, '1, '1);
		load_entry(0, 0, '0, '0);
		ask_span(0, 0);

		// forward spans, last one reaching past the top of the position range
		load_entry(0, 1, 32'd10, 16'd2);
		load_entry(0, 2, 32'hFFFF_0000, '1);
		ask_span(0, POS_MAX);
		ask_span(0, 5);
		ask_span(0, 15);

		// backward spans, first one reaching below position zero
		load_entry(3, 0, 32'd5, '1);
		load_entry(3, 1, 32'd300000, 16'd1);
		load_entry(3, 2, '1, '0);
		ask_span(3, 0);
		ask_span(3, POS_MAX);
		ask_span(3, 299998);

		// search stepping below slot zero
		load_entry(1, 0, 32'd100, 16'd1);
		load_entry(1, 1, 32'd200, 16'd1);
		ask_span(1, 3);
		load_entry(4, 0, 32'd100, 16'd1);
		load_entry(4, 1, 32'd200, 16'd1);
		ask_span(4, 0);
		drain();

		run_phase(35, 62, 250);
		stall_requests++;
		run_phase(35, 62, 260);
		drain();
		run_phase(62, 35, 520);
		drain();
		run_phase(0, 0, 520);
		drain();

		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (tracker.errors == 0 && tracker.outstanding() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule
